// ===== rtl/rrls_pkg.sv =====
// Package for the RIP-relative load scanner: decode constants, register
// indexes and the pipeline stage records. No dependencies.
`default_nettype none

package rrls_pkg;

    localparam int ADDR_W     = 64;
    localparam int OUT_OFF_W  = 32;
    localparam int DISP_W     = 32;
    localparam int CFG_DATA_W = 64;
    localparam int WINDOW_LEN = 6;

    // REX.W with or without REX.R: 0x48 or 0x4C.
    localparam logic [7:0] REX_MASK   = 8'hfb;
    localparam logic [7:0] REX_W      = 8'h48;
    localparam logic [7:0] OPC_LEA    = 8'h8d;
    localparam logic [7:0] OPC_MOV    = 8'h8b;
    // ModRM with mod 00 and rm 101, any reg field.
    localparam logic [7:0] MODRM_MASK = 8'hc7;
    localparam logic [7:0] MODRM_RIP  = 8'h05;
    localparam int         INSN_LEN   = 7;

    typedef enum logic [0:0] {
        REG_TARGET_ADDRESS = 1'b0,
        REG_BASE_ADDRESS   = 1'b1
    } cfg_index_t;

    // Item after the decode stage.
    typedef struct packed {
        logic                  valid;
        logic                  first;
        logic                  last;
        logic                  cand;
        logic [OUT_OFF_W-1:0]  offset;
        logic [DISP_W-1:0]     disp;
    } dec_stage_t;

    // Item after the instruction end has been formed.
    typedef struct packed {
        logic                  valid;
        logic                  first;
        logic                  last;
        logic                  cand;
        logic [OUT_OFF_W-1:0]  offset;
        logic [DISP_W-1:0]     disp;
        logic [ADDR_W-1:0]     end_addr;
    } end_stage_t;

endpackage

`default_nettype wire

// ===== rtl/rrls_target_check.sv =====
// Resolves a RIP-relative operand and compares it with the target address.
// Depends on rrls_pkg.
`default_nettype none

module rrls_target_check (
    input  wire logic [rrls_pkg::ADDR_W-1:0] end_addr,
    input  wire logic [rrls_pkg::DISP_W-1:0] disp,
    input  wire logic [rrls_pkg::ADDR_W-1:0] target_addr,
    output logic                             hit
);
    import rrls_pkg::*;

    logic [ADDR_W:0] resolved;

    // One extra bit catches both a carry past the top and a borrow below zero.
    assign resolved = {1'b0, end_addr}
                    + {{(ADDR_W + 1 - DISP_W){disp[DISP_W-1]}}, disp};

    assign hit = !resolved[ADDR_W]
              && (resolved[ADDR_W-1:0] == target_addr)
              && (target_addr != '0);

endmodule

`default_nettype wire

// ===== rtl/rip_relative_load_scanner.sv =====
// Top level of the RIP-relative load scanner: byte window, decode, address
// pipeline and result register. Depends on rrls_pkg and rrls_target_check.
`default_nettype none

// Channel  Direction  Handshake            Payload
// in       to block   in_valid / in_stall   code_byte, first_byte, last_byte
// out      from block out_valid / out_stall found, match_offset
// cfg      to block   cfg_write             cfg_index, cfg_data
//
// One byte is taken every cycle unless in_stall is high. A byte's result,
// if it causes one, goes through the decode register and the two address
// stages (instruction end, then resolve and compare) to the output register.
// Reset clears the window, the byte count, the pipeline valids and the
// configuration registers. A stalled output holds only the stages behind it
// that would need the output register; bytes that cause no result keep
// flowing, so the input is stalled only when the pipeline is truly full.
module rip_relative_load_scanner #(
    parameter int OFFSET_WIDTH = 32
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    // Configuration.
    input  wire logic                             cfg_write,
    input  wire rrls_pkg::cfg_index_t             cfg_index,
    input  wire logic [rrls_pkg::CFG_DATA_W-1:0]  cfg_data,
    // Input channel.
    input  wire logic                             in_valid,
    output logic                                  in_stall,
    input  wire logic [7:0]                       code_byte,
    input  wire logic                             first_byte,
    input  wire logic                             last_byte,
    // Output channel.
    output logic                                  out_valid,
    input  wire logic                             out_stall,
    output logic                                  found,
    output logic [rrls_pkg::OUT_OFF_W-1:0]        match_offset
);
    import rrls_pkg::*;

    localparam logic [OFFSET_WIDTH-1:0] COUNT_MAX = '1;
    localparam logic [OFFSET_WIDTH-1:0] WIN_COUNT = OFFSET_WIDTH'(WINDOW_LEN);

    // Configuration registers.
    logic [ADDR_W-1:0] target_reg;
    logic [ADDR_W-1:0] base_reg;

    // Scan state.
    logic [7:0]              window_reg [WINDOW_LEN];
    logic [OFFSET_WIDTH-1:0] count_reg;
    logic                    done_reg;
    logic                    done_next;

    // Pipeline.
    dec_stage_t dec_reg, dec_next;
    end_stage_t end_reg, end_next;

    logic                 out_valid_reg, out_valid_next;
    logic                 found_reg;
    logic [OUT_OFF_W-1:0] offset_reg;

    // Handshake and flow control.
    logic accept;
    logic out_free;
    logic emit;
    logic end_go;
    logic end_ready;
    logic dec_ready;
    logic hit;

    // Decode of the current byte against the window.
    logic [7:0]              win_eff [WINDOW_LEN];
    logic [OFFSET_WIDTH-1:0] count_eff;
    logic [OFFSET_WIDTH-1:0] offset_full;
    logic [63:0]             offset_wide;
    logic                    shape_ok;
    logic                    count_ok;
    logic [ADDR_W:0]         end_sum;

    // ------------------------------------------------------------------
    // Configuration.
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            target_reg <= '0;
            base_reg   <= '0;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_TARGET_ADDRESS: target_reg <= cfg_data;
                REG_BASE_ADDRESS:   base_reg   <= cfg_data;
                default:            target_reg <= target_reg;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Flow control. The last stage may always drop an item that gives no
    // result; an item that gives one needs the output register free.
    // ------------------------------------------------------------------
    assign out_free  = !out_valid_reg || !out_stall;
    assign emit      = end_reg.valid && !(done_reg && !end_reg.first)
                    && ((end_reg.cand && hit) || end_reg.last);
    assign end_go    = end_reg.valid && (!emit || out_free);
    assign end_ready = !end_reg.valid || end_go;
    assign dec_ready = !dec_reg.valid || end_ready;
    assign in_stall  = !dec_ready;
    assign accept    = in_valid && dec_ready;

    // ------------------------------------------------------------------
    // Decode stage: a start-of-buffer byte sees an empty window and a zero
    // count. The candidate's displacement ends in the current byte.
    // ------------------------------------------------------------------
    always_comb
    begin
        for (int i = 0; i < WINDOW_LEN; i++)
        begin
            win_eff[i] = first_byte ? 8'h00 : window_reg[i];
        end
        count_eff   = first_byte ? '0 : count_reg;
        offset_full = count_eff - WIN_COUNT;
        offset_wide = 64'(offset_full);

        shape_ok = ((win_eff[0] & REX_MASK) == REX_W)
                && ((win_eff[1] == OPC_LEA) || (win_eff[1] == OPC_MOV))
                && ((win_eff[2] & MODRM_MASK) == MODRM_RIP);
        // Only offsets that the counter still tracks and that fit the
        // reported field are checked.
        count_ok = (count_eff >= WIN_COUNT) && (count_eff != COUNT_MAX)
                && (offset_wide[63:OUT_OFF_W] == '0);

        dec_next.valid  = accept;
        dec_next.first  = first_byte;
        dec_next.last   = last_byte;
        dec_next.cand   = shape_ok && count_ok;
        dec_next.offset = offset_wide[OUT_OFF_W-1:0];
        dec_next.disp   = {code_byte, win_eff[5], win_eff[4], win_eff[3]};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            for (int i = 0; i < WINDOW_LEN; i++)
            begin
                window_reg[i] <= 8'h00;
            end
        end
        else if (accept)
        begin
            // The window keeps shifting after a result; the next buffer
            // start clears it anyway.
            for (int i = 0; i < WINDOW_LEN - 1; i++)
            begin
                window_reg[i] <= win_eff[i+1];
            end
            window_reg[WINDOW_LEN-1] <= code_byte;
            count_reg <= (count_eff == COUNT_MAX) ? count_eff
                                                  : count_eff + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dec_reg <= '0;
        end
        else
        begin
            if (dec_ready)
            begin
                dec_reg.valid <= dec_next.valid;
            end
            if (accept)
            begin
                dec_reg.first  <= dec_next.first;
                dec_reg.last   <= dec_next.last;
                dec_reg.cand   <= dec_next.cand;
                dec_reg.offset <= dec_next.offset;
                dec_reg.disp   <= dec_next.disp;
            end
        end
    end

    // ------------------------------------------------------------------
    // Instruction end: base + offset + 7. A carry out of 64 bits skips the
    // candidate.
    // ------------------------------------------------------------------
    always_comb
    begin
        end_sum = {1'b0, base_reg} + (ADDR_W + 1)'(dec_reg.offset)
                + (ADDR_W + 1)'(INSN_LEN);

        end_next.valid    = dec_reg.valid;
        end_next.first    = dec_reg.first;
        end_next.last     = dec_reg.last;
        end_next.cand     = dec_reg.cand && !end_sum[ADDR_W];
        end_next.offset   = dec_reg.offset;
        end_next.disp     = dec_reg.disp;
        end_next.end_addr = end_sum[ADDR_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            end_reg <= '0;
        end
        else
        begin
            if (end_ready)
            begin
                end_reg.valid <= end_next.valid;
            end
            if (end_ready && dec_reg.valid)
            begin
                end_reg.first    <= end_next.first;
                end_reg.last     <= end_next.last;
                end_reg.cand     <= end_next.cand;
                end_reg.offset   <= end_next.offset;
                end_reg.disp     <= end_next.disp;
                end_reg.end_addr <= end_next.end_addr;
            end
        end
    end

    // ------------------------------------------------------------------
    // Resolve and compare, then the result register.
    // ------------------------------------------------------------------
    rrls_target_check u_target_check (
        .end_addr    (end_reg.end_addr),
        .disp        (end_reg.disp),
        .target_addr (target_reg),
        .hit         (hit)
    );

    // The buffer is finished once it has given its result; only a new
    // buffer start reopens it.
    always_comb
    begin
        done_next = done_reg;
        if (end_go)
        begin
            if (end_reg.first)
            begin
                done_next = 1'b0;
            end
            if (emit)
            begin
                done_next = 1'b1;
            end
        end
    end

    always_comb
    begin
        if (end_go && emit)
        begin
            out_valid_next = 1'b1;
        end
        else
        begin
            out_valid_next = out_valid_reg && out_stall;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            done_reg      <= done_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (end_go && emit)
        begin
            found_reg  <= end_reg.cand && hit;
            offset_reg <= (end_reg.cand && hit) ? end_reg.offset : '0;
        end
    end

    assign out_valid    = out_valid_reg;
    assign found        = found_reg;
    assign match_offset = offset_reg;

`ifndef SYNTHESIS
    // A buffer that ended without a match reports offset zero.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !found |-> match_offset == '0)
        else $error("no-match result carries a non-zero offset");

    // Once a result has left the last stage the buffer is closed.
    assert property (@(posedge clk) disable iff (!rst_n)
        end_go && emit |=> done_reg)
        else $error("buffer not closed after its result");

    // The byte counter saturates instead of wrapping.
    assert property (@(posedge clk) disable iff (!rst_n)
        accept && !first_byte && count_reg == COUNT_MAX |=> count_reg == COUNT_MAX)
        else $error("byte counter wrapped");

    // A result is never overwritten while it is held by a stall.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_stall |-> !(end_go && emit))
        else $error("held result overwritten");
`endif

endmodule

`default_nettype wire

// ===== verif/rip_relative_load_scanner_test.sv =====
// Self-checking testbench for the RIP-relative load scanner: byte streams with planted
// LEA/MOV instructions, a local scan predictor and a result checker.
// Depends on rrls_pkg and rip_relative_load_scanner; reads no files.
`timescale 1ns / 100ps

module rip_relative_load_scanner_test;

    // The count of bytes taken in a buffer is kept at the width of the block's parameter
    // and saturates at its all-ones value.
    localparam int SCAN_COUNT_W = 32;
    localparam logic [SCAN_COUNT_W-1:0] COUNT_LIMIT = '1;

    // Instruction form that the scanner looks for, written out independently of the
    // package so that a wrong constant there shows up as a mismatch.
    localparam logic [7:0] REX_PREFIX_MASK = 8'hfb;
    localparam logic [7:0] REX_W_PLAIN     = 8'h48;
    localparam logic [7:0] REX_W_WITH_R    = 8'h4c;
    localparam logic [7:0] OPCODE_LEA      = 8'h8d;
    localparam logic [7:0] OPCODE_MOV      = 8'h8b;
    localparam logic [7:0] MODRM_FORM_MASK = 8'hc7;
    localparam logic [7:0] MODRM_RIP_REL   = 8'h05;
    localparam int         INSN_BYTES      = 7;

    localparam int SETTLE_CYCLES   = 8;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam logic [63:0] ADDR_MAX = 64'hffff_ffff_ffff_ffff;

    typedef struct packed {
        logic        found;
        logic [31:0] match_offset;
    } scan_result_t;

    logic clk;
    logic rst_n = 1'b0;

    logic                              cfg_write = 1'b0;
    rrls_pkg::cfg_index_t              cfg_index = rrls_pkg::REG_TARGET_ADDRESS;
    logic [rrls_pkg::CFG_DATA_W-1:0]   cfg_data  = '0;

    logic        in_valid   = 1'b0;
    logic        in_stall;
    logic [7:0]  code_byte  = 8'h00;
    logic        first_byte = 1'b0;
    logic        last_byte  = 1'b0;

    logic        out_valid;
    logic        out_stall  = 1'b0;
    logic        found;
    logic [rrls_pkg::OUT_OFF_W-1:0] match_offset;

    // Copy of the scanner state as the predictor sees it.
    logic [7:0]              scan_window [0:5];
    logic [SCAN_COUNT_W-1:0] scan_count = '0;
    logic                    scan_done  = 1'b0;
    logic [63:0]             cfg_target = '0;
    logic [63:0]             cfg_base   = '0;

    scan_result_t pending_results[$];
    int           taken_count    = 0;
    int           mismatch_count = 0;

    // Idling: percentage of cycles in which the sender holds back an item and in which
    // the receiver stalls. A separate long hold-off can be started by event.
    int   send_idle_pct  = 0;
    int   recv_stall_pct = 0;
    logic long_hold      = 1'b0;
    event hold_off_start;

    rip_relative_load_scanner #(
        .OFFSET_WIDTH (SCAN_COUNT_W)
    ) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .code_byte    (code_byte),
        .first_byte   (first_byte),
        .last_byte    (last_byte),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .found        (found),
        .match_offset (match_offset)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        for (int i = 0; i < 6; i++)
        begin
            scan_window[i] = 8'h00;
        end
    end

    // Safety net: far beyond the slowest correct run, even with every idling phase.
    initial
    begin
        #2000000;
        $display("rip_relative_load_scanner_test: done, errors");
        $finish;
    end

    // ------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------

    // Decides whether the six bytes in the window plus the incoming byte form a
    // RIP-relative LEA or MOV whose resolved operand equals the target register. The
    // instruction end and the resolved address are formed with spare upper bits, so
    // that any step outside the 64-bit range is caught rather than wrapped.
    function automatic logic rip_target_hit(input logic [7:0] top_byte,
                                            input logic [63:0] offset);
        logic [64:0]        insn_end;
        logic [31:0]        disp;
        logic signed [66:0] resolved;
        if ((scan_window[0] & REX_PREFIX_MASK) != REX_W_PLAIN)
            return 1'b0;
        if (scan_window[1] != OPCODE_LEA && scan_window[1] != OPCODE_MOV)
            return 1'b0;
        if ((scan_window[2] & MODRM_FORM_MASK) != MODRM_RIP_REL)
            return 1'b0;
        // A zero target is treated as unset and never matches.
        if (cfg_target == 64'd0)
            return 1'b0;
        insn_end = {1'b0, cfg_base} + {1'b0, offset} + 65'(INSN_BYTES);
        if (insn_end[64])
            return 1'b0;
        disp = {top_byte, scan_window[5], scan_window[4], scan_window[3]};
        resolved = $signed({2'b00, insn_end}) + $signed(disp);
        // Negative or beyond the top of the address space: the candidate is skipped.
        if (resolved[66:64] != 3'b000)
            return 1'b0;
        return resolved[63:0] == cfg_target;
    endfunction

    // Takes one accepted item into the predicted state and queues the result, if any,
    // that the item causes.
    task automatic predict_byte(input logic [7:0] value, input logic is_first,
                                input logic is_last);
        logic        hit;
        logic [63:0] offset;
        hit = 1'b0;
        offset = '0;
        taken_count++;
        if (is_first)
        begin
            for (int i = 0; i < 6; i++)
            begin
                scan_window[i] = 8'h00;
            end
            scan_count = '0;
            scan_done = 1'b0;
        end
        // Once the buffer has given its result, everything up to the next start is
        // ignored.
        if (scan_done)
            return;
        // A candidate is only looked at while the counter has not saturated and the
        // offset still fits the output field.
        if (scan_count >= 6 && scan_count != COUNT_LIMIT)
        begin
            offset = 64'(scan_count) - 64'd6;
            hit = (offset <= 64'hffff_ffff) && rip_target_hit(value, offset);
        end
        for (int i = 0; i < 5; i++)
        begin
            scan_window[i] = scan_window[i + 1];
        end
        scan_window[5] = value;
        if (scan_count != COUNT_LIMIT)
            scan_count++;
        if (hit)
        begin
            pending_results.push_back(scan_result_t'{found: 1'b1,
                                                     match_offset: offset[31:0]});
            scan_done = 1'b1;
        end
        else if (is_last)
        begin
            pending_results.push_back(scan_result_t'{found: 1'b0, match_offset: 32'd0});
            scan_done = 1'b1;
        end
    endtask

    // ------------------------------------------------------------------
    // Checking
    // ------------------------------------------------------------------

    task automatic report_mismatch(input string what);
        $display("MISMATCH at %0t ns: %s", $time, what);
        mismatch_count++;
    endtask

    // Every result that the receiver accepts is compared with the oldest prediction.
    always @(posedge clk)
    begin : result_check
        scan_result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_results.size() == 0)
            begin
                report_mismatch($sformatf("unexpected result found=%0b offset=%0d",
                                          found, match_offset));
            end
            else
            begin
                want = pending_results.pop_front();
                if (found !== want.found)
                    report_mismatch($sformatf("found is %0b, predicted %0b",
                                              found, want.found));
                if (match_offset !== want.match_offset)
                    report_mismatch($sformatf("match_offset is %0d, predicted %0d",
                                              match_offset, want.match_offset));
            end
        end
    end

    // ------------------------------------------------------------------
    // Receiver
    // ------------------------------------------------------------------

    always @(posedge clk)
    begin
        out_stall <= long_hold || ($urandom_range(99) < recv_stall_pct);
    end

    // The long hold-off keeps the output stalled while the sender carries on, so that
    // the pipeline fills and the input stalls.
    initial
    begin
        forever
        begin
            @(hold_off_start);
            long_hold <= 1'b1;
            repeat (HOLD_OFF_CYCLES) @(posedge clk);
            long_hold <= 1'b0;
        end
    end

    // ------------------------------------------------------------------
    // Sender and configuration
    // ------------------------------------------------------------------

    // Offers one item and waits until it is accepted; the payload stands still while
    // the block stalls. Idle cycles, if any, follow the acceptance.
    task automatic send_byte(input logic [7:0] value, input logic is_first,
                             input logic is_last);
        in_valid   <= 1'b1;
        code_byte  <= value;
        first_byte <= is_first;
        last_byte  <= is_last;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        predict_byte(value, is_first, is_last);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
    endtask

    // Waits until every predicted result has come and then lets the pipeline empty of
    // items that cause none.
    task automatic wait_idle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Registers are only written with the block idle.
    task automatic configure_scan(input logic [63:0] target, input logic [63:0] base);
        wait_idle();
        cfg_write <= 1'b1;
        cfg_index <= rrls_pkg::REG_TARGET_ADDRESS;
        cfg_data  <= target;
        @(posedge clk);
        cfg_index <= rrls_pkg::REG_BASE_ADDRESS;
        cfg_data  <= base;
        @(posedge clk);
        cfg_write <= 1'b0;
        cfg_target = target;
        cfg_base = base;
    endtask

    task automatic set_idling(input int send_pct, input int stall_pct);
        send_idle_pct = send_pct;
        recv_stall_pct = stall_pct;
    endtask

    function automatic logic [63:0] random_address();
        return {$urandom, $urandom};
    endfunction

    // Filler is biased towards the bytes of the instruction form, so that partial and
    // accidental candidates turn up often.
    function automatic logic [7:0] filler_byte();
        case ($urandom_range(9))
            0: return REX_W_PLAIN;
            1: return REX_W_WITH_R;
            2: return OPCODE_LEA;
            3: return OPCODE_MOV;
            4: return {2'b00, 3'($urandom_range(7)), 3'b101};
            default: return 8'($urandom);
        endcase
    endfunction

    function automatic int buffer_length();
        case ($urandom_range(19))
            0, 1, 2, 3: return $urandom_range(1, 6);
            4, 5, 6:    return $urandom_range(41, 120);
            default:    return $urandom_range(7, 40);
        endcase
    endfunction

    // Sends one buffer of random filler with up to plant_max instructions planted in
    // it. A planted displacement is the one that would reach the target modulo 2^64, so
    // whether it really matches depends on the range checks; some are nudged off by a
    // little or get a spoilt prefix or ModRM. Most buffers are well formed; a few carry
    // random start and end marks, and a few are cut off without an end mark.
    task automatic send_buffer(input int len, input int plant_max);
        logic [7:0]  bytes_q[$];
        logic [63:0] diff;
        logic [31:0] disp;
        int          o;
        int          form;
        logic        is_first;
        logic        is_last;
        for (int i = 0; i < len; i++)
        begin
            bytes_q.push_back(filler_byte());
        end
        if (len >= INSN_BYTES)
        begin
            repeat ($urandom_range(plant_max))
            begin
                o = $urandom_range(len - INSN_BYTES);
                diff = cfg_target - cfg_base - 64'(o) - 64'(INSN_BYTES);
                disp = diff[31:0];
                if ($urandom_range(4) == 0)
                    disp = disp + 32'($urandom_range(6)) - 32'd3;
                bytes_q[o] = $urandom_range(1) ? REX_W_PLAIN : REX_W_WITH_R;
                if ($urandom_range(9) == 0)
                    bytes_q[o] = bytes_q[o] ^ 8'(1 << $urandom_range(7));
                bytes_q[o + 1] = $urandom_range(1) ? OPCODE_LEA : OPCODE_MOV;
                bytes_q[o + 2] = {2'b00, 3'($urandom_range(7)), 3'b101};
                if ($urandom_range(9) == 0)
                    bytes_q[o + 2][7:6] = 2'($urandom_range(3));
                bytes_q[o + 3] = disp[7:0];
                bytes_q[o + 4] = disp[15:8];
                bytes_q[o + 5] = disp[23:16];
                bytes_q[o + 6] = disp[31:24];
            end
        end
        form = $urandom_range(19);
        for (int i = 0; i < len; i++)
        begin
            is_first = (form == 0) ? ($urandom_range(19) == 0) : (i == 0);
            is_last  = (form == 0) ? ($urandom_range(19) == 0)
                                   : (form != 1 && i == len - 1);
            send_byte(bytes_q[i], is_first, is_last);
        end
    endtask

    // Sends random buffers until about the given number of items have been taken.
    task automatic send_buffers(input int item_goal);
        int start;
        start = taken_count;
        while (taken_count - start < item_goal)
            send_buffer(buffer_length(), 2);
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Hand-made items straight after reset: a LEA at offset 0 with no start mark, an
    // item after the result, a short buffer, a one-byte buffer and a MOV with REX.R
    // at offset 1.
    task automatic test_directed();
        logic [63:0] base;
        base = 64'h0000_7ff6_1234_0000;
        configure_scan(base + 64'h100, base);
        set_idling(0, 0);
        // Displacement 0x100 - 7 reaches the target from offset 0.
        send_byte(REX_W_PLAIN, 1'b0, 1'b0);
        send_byte(OPCODE_LEA, 1'b0, 1'b0);
        send_byte(MODRM_RIP_REL, 1'b0, 1'b0);
        send_byte(8'hf9, 1'b0, 1'b0);
        send_byte(8'h00, 1'b0, 1'b0);
        send_byte(8'h00, 1'b0, 1'b0);
        send_byte(8'h00, 1'b0, 1'b1);
        // Ignored: the buffer has already reported.
        send_byte(8'h90, 1'b0, 1'b0);
        // Too short to hold an instruction.
        send_byte(REX_W_PLAIN, 1'b1, 1'b0);
        send_byte(OPCODE_LEA, 1'b0, 1'b0);
        send_byte(MODRM_RIP_REL, 1'b0, 1'b1);
        send_byte(8'hff, 1'b1, 1'b1);
        // MOV with REX.R and reg field 7, one byte in: displacement 0x100 - 8.
        send_byte(8'h90, 1'b1, 1'b0);
        send_byte(REX_W_WITH_R, 1'b0, 1'b0);
        send_byte(OPCODE_MOV, 1'b0, 1'b0);
        send_byte(8'h3d, 1'b0, 1'b0);
        send_byte(8'hf8, 1'b0, 1'b0);
        send_byte(8'h00, 1'b0, 1'b0);
        send_byte(8'h00, 1'b0, 1'b0);
        send_byte(8'h00, 1'b0, 1'b1);
    endtask

    // Ordinary addresses with the target a little ahead of the buffer, so that planted
    // instructions give displacements of either sign.
    task automatic test_plain_matches();
        logic [63:0] base;
        base = {16'h0000, 16'($urandom), $urandom};
        configure_scan(base + 64'($urandom_range(40, 400)), base);
        set_idling(0, 0);
        send_buffers(200);
    endtask

    // Buffer at address zero with a target just above it: every match needs a
    // negative displacement that ends three bytes above the bottom of the range.
    task automatic test_negative_displacement();
        configure_scan(64'd3, 64'd0);
        set_idling(83, 0);
        send_buffers(200);
    endtask

    // Target at the very top of the address space with the buffer just below it;
    // longer buffers run past the top and their later candidates are skipped.
    task automatic test_top_of_address_space();
        configure_scan(ADDR_MAX, ADDR_MAX - 64'd40);
        set_idling(0, 83);
        send_buffers(200);
    endtask

    // Buffer at the top address: every instruction end leaves the 64-bit range, so
    // candidates that match modulo 2^64 must all be skipped.
    task automatic test_instruction_end_wrap();
        configure_scan(64'd5, ADDR_MAX);
        set_idling(26, 26);
        send_buffers(100);
    endtask

    // A zero target never matches, even where the resolved address is zero.
    task automatic test_zero_target();
        configure_scan(64'd0, random_address());
        set_idling(0, 0);
        send_buffers(100);
    endtask

    // Displacements around the largest positive value: offset 17 needs exactly
    // 0x7fffffff, earlier offsets would need one that reads as negative.
    task automatic test_large_positive_disp();
        logic [63:0] base;
        base = {8'h00, 24'($urandom), $urandom};
        configure_scan(base + 64'd7 + 64'h8000_0010, base);
        set_idling(26, 26);
        send_buffers(150);
    endtask

    // Displacements around the most negative value: offset 16 needs exactly
    // -2^31, later offsets would need one out of reach.
    task automatic test_large_negative_disp();
        logic [63:0] base;
        base = {8'h01, 24'($urandom), $urandom};
        configure_scan(base + 64'd7 + 64'h10 - 64'h8000_0000, base);
        set_idling(0, 83);
        send_buffers(150);
    endtask

    // Buffer at zero with a target near the top: the planted displacements would take
    // the resolved address below zero, which must be skipped.
    task automatic test_target_underflow();
        configure_scan(ADDR_MAX - 64'd4, 64'd0);
        set_idling(83, 0);
        send_buffers(80);
    endtask

    // Very short buffers, most of them giving a result, sent flat out while the
    // receiver holds off for a long stretch, so that results back up into the block.
    task automatic test_output_backpressure();
        configure_scan(64'h0000_0000_0040_0100, 64'h0000_0000_0040_0000);
        set_idling(0, 0);
        -> hold_off_start;
        repeat (80)
            send_buffer($urandom_range(1, 2), 0);
    endtask

    // Fully random base; the target is either close to it or anywhere at all.
    task automatic test_random_settings();
        logic [63:0] base;
        base = random_address();
        if ($urandom_range(1))
            configure_scan(base + 64'($urandom_range(0, 600)) - 64'd100, base);
        else
            configure_scan(random_address(), base);
        set_idling(0, 0);
        send_buffers(100);
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------

    initial
    begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_plain_matches();
        test_negative_displacement();
        test_top_of_address_space();
        test_instruction_end_wrap();
        test_zero_target();
        test_large_positive_disp();
        test_large_negative_disp();
        test_target_underflow();
        test_output_backpressure();
        test_random_settings();
        wait_idle();
        if (mismatch_count == 0)
            $display("rip_relative_load_scanner_test: done, clean");
        else
            $display("rip_relative_load_scanner_test: done, errors");
        $finish;
    end

endmodule
